/* sv/dahdsr_pkg.sv */
// Shared constants of the DAHDSR envelope level block.
`default_nettype none
package dahdsr_pkg;

    localparam int TIME_BITS_DEF       = 48;
    localparam int DURATION_BITS_DEF   = 24;
    localparam int LEVEL_FRAC_BITS_DEF = 15;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DELAY   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HOLD    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd5;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_QUOT      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONE_MINUS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONST     = 2'd2;

endpackage
`default_nettype wire

/* sv/dahdsr_envelope_level.sv */
// Top level of the DAHDSR envelope level block.
// The s_ channel takes one word per cycle while s_ready is high:
// now_time, on_time, off_time and release_from. The m_ channel returns one
// level word for each input word, in order, as unsigned Q1.15 where 32768
// is full level. Durations and the sustain level are to be written through
// the APB port while the block is idle; the block does not enforce this;
// pready is always high and every register reads back. A word taken on the
// s_ channel passes three phase decode stages, one multiply stage, one
// stage per quotient bit of the divider (LEVEL_FRAC_BITS + 1 of them) and
// the output register. Throughput is one word per cycle while the receiver
// does not stall, set by the fully pipelined divider. Each stage holds its
// own valid bit, so when the receiver stalls the pipeline keeps filling its
// empty stages and s_ready falls only once every stage holds a word; no
// word is dropped or repeated. Reset empties the pipeline, sets all
// durations to zero and the sustain level to full.
`default_nettype none
module dahdsr_envelope_level #(
    parameter int TIME_BITS       = dahdsr_pkg::TIME_BITS_DEF,
    parameter int DURATION_BITS   = dahdsr_pkg::DURATION_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = dahdsr_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dahdsr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dahdsr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dahdsr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [TIME_BITS-1:0]              s_now_time,
    input  wire logic [TIME_BITS-1:0]              s_on_time,
    input  wire logic [TIME_BITS-1:0]              s_off_time,
    input  wire logic [LEVEL_FRAC_BITS:0]          s_release_from,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [LEVEL_FRAC_BITS:0]          m_level
);

    localparam int D  = DURATION_BITS;
    localparam int LW = LEVEL_FRAC_BITS + 1;

    logic [D-1:0]  delay_len, attack_len, hold_len, decay_len, release_len;
    logic [LW-1:0] sustain_level;

    logic                          ph_valid, ph_ready;
    logic [D-1:0]                  ph_mul_a, ph_divisor;
    logic [LW-1:0]                 ph_mul_b, ph_const;
    logic [dahdsr_pkg::MODE_W-1:0] ph_mode;

    logic          dv_valid, dv_ready;
    logic [LW-1:0] dv_level;

    logic          m_valid_reg;
    logic [LW-1:0] level_reg;

    dahdsr_cfg #(
        .DURATION_BITS   (DURATION_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .delay_len     (delay_len),
        .attack_len    (attack_len),
        .hold_len      (hold_len),
        .decay_len     (decay_len),
        .sustain_level (sustain_level),
        .release_len   (release_len)
    );

    dahdsr_phase #(
        .TIME_BITS       (TIME_BITS),
        .DURATION_BITS   (DURATION_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_phase (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .delay_len     (delay_len),
        .attack_len    (attack_len),
        .hold_len      (hold_len),
        .decay_len     (decay_len),
        .sustain_level (sustain_level),
        .release_len   (release_len),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .now_time      (s_now_time),
        .on_time       (s_on_time),
        .off_time      (s_off_time),
        .release_from  (s_release_from),
        .out_valid     (ph_valid),
        .out_ready     (ph_ready),
        .mul_a         (ph_mul_a),
        .mul_b         (ph_mul_b),
        .divisor       (ph_divisor),
        .mode          (ph_mode),
        .const_level   (ph_const)
    );

    dahdsr_div #(
        .DURATION_BITS   (DURATION_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (ph_valid),
        .in_ready    (ph_ready),
        .mul_a       (ph_mul_a),
        .mul_b       (ph_mul_b),
        .divisor     (ph_divisor),
        .mode        (ph_mode),
        .const_level (ph_const),
        .out_valid   (dv_valid),
        .out_ready   (dv_ready),
        .level       (dv_level)
    );

    assign dv_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dv_ready) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dv_ready) begin
            level_reg <= dv_level;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = level_reg;

endmodule
`default_nettype wire

/* sv/dahdsr_cfg.sv */
// APB configuration registers of the DAHDSR envelope level block.
`default_nettype none
module dahdsr_cfg #(
    parameter int DURATION_BITS   = dahdsr_pkg::DURATION_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = dahdsr_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dahdsr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dahdsr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dahdsr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                   pready,
    output logic      [DURATION_BITS-1:0]          delay_len,
    output logic      [DURATION_BITS-1:0]          attack_len,
    output logic      [DURATION_BITS-1:0]          hold_len,
    output logic      [DURATION_BITS-1:0]          decay_len,
    output logic      [LEVEL_FRAC_BITS:0]          sustain_level,
    output logic      [DURATION_BITS-1:0]          release_len
);

    localparam int D  = DURATION_BITS;
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam logic [LW-1:0] ONE = LW'(1) << LEVEL_FRAC_BITS;

    logic [D-1:0]  delay_reg, attack_reg, hold_reg, decay_reg, release_reg;
    logic [LW-1:0] sustain_reg;
    logic          wr_en;
    logic [dahdsr_pkg::REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[dahdsr_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= '0;
            attack_reg  <= '0;
            hold_reg    <= '0;
            decay_reg   <= '0;
            sustain_reg <= ONE;
            release_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                dahdsr_pkg::REG_DELAY:   delay_reg   <= pwdata[D-1:0];
                dahdsr_pkg::REG_ATTACK:  attack_reg  <= pwdata[D-1:0];
                dahdsr_pkg::REG_HOLD:    hold_reg    <= pwdata[D-1:0];
                dahdsr_pkg::REG_DECAY:   decay_reg   <= pwdata[D-1:0];
                dahdsr_pkg::REG_SUSTAIN: sustain_reg <= pwdata[LW-1:0];
                dahdsr_pkg::REG_RELEASE: release_reg <= pwdata[D-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            dahdsr_pkg::REG_DELAY:   prdata = dahdsr_pkg::APB_DATA_W'(delay_reg);
            dahdsr_pkg::REG_ATTACK:  prdata = dahdsr_pkg::APB_DATA_W'(attack_reg);
            dahdsr_pkg::REG_HOLD:    prdata = dahdsr_pkg::APB_DATA_W'(hold_reg);
            dahdsr_pkg::REG_DECAY:   prdata = dahdsr_pkg::APB_DATA_W'(decay_reg);
            dahdsr_pkg::REG_SUSTAIN: prdata = dahdsr_pkg::APB_DATA_W'(sustain_reg);
            dahdsr_pkg::REG_RELEASE: prdata = dahdsr_pkg::APB_DATA_W'(release_reg);
            default:                 prdata = '0;
        endcase
    end

    assign delay_len     = delay_reg;
    assign attack_len    = attack_reg;
    assign hold_len      = hold_reg;
    assign decay_len     = decay_reg;
    assign sustain_level = sustain_reg;
    assign release_len   = release_reg;

endmodule
`default_nettype wire

/* sv/dahdsr_phase.sv */
// Three-stage phase decode: elapsed times, phase compares and divider operand selection.
`default_nettype none
module dahdsr_phase #(
    parameter int TIME_BITS       = dahdsr_pkg::TIME_BITS_DEF,
    parameter int DURATION_BITS   = dahdsr_pkg::DURATION_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = dahdsr_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [DURATION_BITS-1:0]      delay_len,
    input  wire logic [DURATION_BITS-1:0]      attack_len,
    input  wire logic [DURATION_BITS-1:0]      hold_len,
    input  wire logic [DURATION_BITS-1:0]      decay_len,
    input  wire logic [LEVEL_FRAC_BITS:0]      sustain_level,
    input  wire logic [DURATION_BITS-1:0]      release_len,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [TIME_BITS-1:0]          now_time,
    input  wire logic [TIME_BITS-1:0]          on_time,
    input  wire logic [TIME_BITS-1:0]          off_time,
    input  wire logic [LEVEL_FRAC_BITS:0]      release_from,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [DURATION_BITS-1:0]      mul_a,
    output logic      [LEVEL_FRAC_BITS:0]      mul_b,
    output logic      [DURATION_BITS-1:0]      divisor,
    output logic      [dahdsr_pkg::MODE_W-1:0] mode,
    output logic      [LEVEL_FRAC_BITS:0]      const_level
);

    localparam int T  = TIME_BITS;
    localparam int D  = DURATION_BITS;
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int SW = D + 2;
    localparam int CW = (T > SW) ? T : SW;
    localparam logic [LW-1:0] ONE = LW'(1) << LEVEL_FRAC_BITS;

    logic [2:0] valid_reg;
    logic [2:0] en;

    logic [T-1:0]  el1_reg, rel1_reg;
    logic          relsel1_reg;
    logic [LW-1:0] rf1_reg;

    logic [T-1:0]  after2_reg;
    logic          in_delay2_reg, rel_act2_reg, relsel2_reg;
    logic [D-1:0]  rel_rem2_reg;
    logic [LW-1:0] rf2_reg;

    logic [D-1:0]              mul_a_reg, divisor_reg;
    logic [D-1:0]              mul_a_next, divisor_next;
    logic [LW-1:0]             mul_b_reg, const_reg, mul_b_next, const_next;
    logic [dahdsr_pkg::MODE_W-1:0] mode_reg, mode_next;

    logic [SW-1:0] ah, ahd;
    logic [CW-1:0] after_x, ah_x, ahd_x, att_x, tdec_x;
    logic [LW-1:0] sus;

    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            el1_reg     <= now_time - on_time;
            rel1_reg    <= now_time - off_time;
            relsel1_reg <= (off_time != '0) && (now_time >= off_time);
            rf1_reg     <= (release_from > ONE) ? ONE : release_from;
        end
        if (en[1]) begin
            after2_reg    <= el1_reg - T'(delay_len);
            in_delay2_reg <= el1_reg < T'(delay_len);
            rel_act2_reg  <= rel1_reg < T'(release_len);
            rel_rem2_reg  <= release_len - rel1_reg[D-1:0];
            relsel2_reg   <= relsel1_reg;
            rf2_reg       <= rf1_reg;
        end
        if (en[2]) begin
            mul_a_reg   <= mul_a_next;
            mul_b_reg   <= mul_b_next;
            divisor_reg <= divisor_next;
            mode_reg    <= mode_next;
            const_reg   <= const_next;
        end
    end

    always_comb begin
        ah      = SW'(attack_len) + SW'(hold_len);
        ahd     = ah + SW'(decay_len);
        after_x = CW'(after2_reg);
        att_x   = CW'(attack_len);
        ah_x    = CW'(ah);
        ahd_x   = CW'(ahd);
        tdec_x  = after_x - ah_x;
        sus     = (sustain_level > ONE) ? ONE : sustain_level;

        mul_a_next   = after2_reg[D-1:0];
        mul_b_next   = ONE;
        divisor_next = attack_len;
        mode_next    = dahdsr_pkg::MODE_CONST;
        const_next   = '0;
        priority if (relsel2_reg) begin
            if (rel_act2_reg) begin
                mul_a_next   = rel_rem2_reg;
                mul_b_next   = rf2_reg;
                divisor_next = release_len;
                mode_next    = dahdsr_pkg::MODE_QUOT;
            end
        end else if (in_delay2_reg) begin
            const_next = '0;
        end else if (after_x < att_x) begin
            mode_next = dahdsr_pkg::MODE_QUOT;
        end else if (after_x < ah_x) begin
            const_next = ONE;
        end else if (after_x < ahd_x) begin
            mul_a_next   = tdec_x[D-1:0];
            mul_b_next   = ONE - sus;
            divisor_next = decay_len;
            mode_next    = dahdsr_pkg::MODE_ONE_MINUS;
        end else begin
            const_next = sus;
        end
    end

    assign out_valid   = valid_reg[2];
    assign mul_a       = mul_a_reg;
    assign mul_b       = mul_b_reg;
    assign divisor     = divisor_reg;
    assign mode        = mode_reg;
    assign const_level = const_reg;

endmodule
`default_nettype wire

/* sv/dahdsr_div.sv */
// Multiply stage and pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module dahdsr_div #(
    parameter int DURATION_BITS   = dahdsr_pkg::DURATION_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = dahdsr_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [DURATION_BITS-1:0]      mul_a,
    input  wire logic [LEVEL_FRAC_BITS:0]      mul_b,
    input  wire logic [DURATION_BITS-1:0]      divisor,
    input  wire logic [dahdsr_pkg::MODE_W-1:0] mode,
    input  wire logic [LEVEL_FRAC_BITS:0]      const_level,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [LEVEL_FRAC_BITS:0]      level
);

    localparam int D  = DURATION_BITS;
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int Q  = LW;
    localparam int NW = D + LW;
    localparam int NS = Q + 1;
    localparam logic [LW-1:0] ONE = LW'(1) << LEVEL_FRAC_BITS;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    logic [NW-1:0]                 rem_reg  [NS];
    logic [Q-1:0]                  q_reg    [NS];
    logic [D-1:0]                  div_reg  [NS];
    logic [dahdsr_pkg::MODE_W-1:0] mode_reg [NS];
    logic [LW-1:0]                 cst_reg  [NS];

    logic [NW-1:0] rem_next [Q];
    logic [Q-1:0]  q_next   [Q];
    logic [NW-1:0] dsh      [Q];

    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end
    assign in_ready = en[0];

    always_comb begin
        for (int s = 1; s <= Q; s++) begin
            dsh[s-1]      = NW'(div_reg[s-1]) << (Q - s);
            rem_next[s-1] = rem_reg[s-1];
            q_next[s-1]   = q_reg[s-1];
            if (rem_reg[s-1] >= dsh[s-1]) begin
                rem_next[s-1]       = rem_reg[s-1] - dsh[s-1];
                q_next[s-1][Q - s]  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) begin
                if (en[s]) valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= NW'(mul_a) * NW'(mul_b);
            q_reg[0]    <= '0;
            div_reg[0]  <= divisor;
            mode_reg[0] <= mode;
            cst_reg[0]  <= const_level;
        end
        for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
                rem_reg[s]  <= rem_next[s-1];
                q_reg[s]    <= q_next[s-1];
                div_reg[s]  <= div_reg[s-1];
                mode_reg[s] <= mode_reg[s-1];
                cst_reg[s]  <= cst_reg[s-1];
            end
        end
    end

    always_comb begin
        unique case (mode_reg[NS-1])
            dahdsr_pkg::MODE_QUOT:      level = q_reg[NS-1];
            dahdsr_pkg::MODE_ONE_MINUS: level = ONE - q_reg[NS-1];
            default:                    level = cst_reg[NS-1];
        endcase
    end

    assign out_valid = valid_reg[NS-1];

endmodule
`default_nettype wire
